// File: rtl/slc_pkg.sv
package slc_pkg;

  // Cache geometry (powers of two: set and tag come from bit fields)
  localparam int unsigned LINE_SIZE  = 64;
  localparam int unsigned SETS       = 32;
  localparam int unsigned WAYS       = 4;

  // Field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned OFF_W    = $clog2(LINE_SIZE);
  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned SET_W    = (SETS > 1) ? SET_BITS : 1;
  localparam int unsigned TAG_W    = ADDR_W - OFF_W - SET_BITS;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_W   = WAY_W;

  // Result stream: hit, miss count, padded to bytes
  localparam int unsigned OUT_W    = ((1 + CNT_W + 7) / 8) * 8;
  localparam int unsigned PAD_W    = OUT_W - 1 - CNT_W;

  // Request queue between front and back
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // Classified lookup request
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_idx;
  } req_t;

  // Front to queue
  typedef struct packed {
    logic valid;
    req_t req;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic valid;
    req_t req;
  } q_out_t;

  // Back status
  typedef struct packed {
    logic cmp;   // tags read, compare and update under way
    logic done;  // request retires this cycle
  } bk_stat_t;

endpackage

// File: rtl/slc_ram.sv
module slc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/slc_front.sv
module slc_front (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [slc_pkg::ADDR_W-1:0]  s_axis_tdata,   // [31:0] byte_address
  input  logic                        q_full_i,
  output slc_pkg::push_t              push_o
);
  import slc_pkg::*;

  logic [SET_W-1:0] set_idx;

  // Set index: line number bits right above the line offset
  if (SET_BITS > 0) begin : g_set
    assign set_idx = s_axis_tdata[OFF_W +: SET_W];
  end else begin : g_one_set
    assign set_idx = '0;
  end

  // Accept whenever the queue has room
  assign s_axis_tready       = !q_full_i;
  assign push_o.valid        = s_axis_tvalid && !q_full_i;
  assign push_o.req.set_idx  = set_idx;
  assign push_o.req.tag      = s_axis_tdata[ADDR_W-1 -: TAG_W];

endmodule

// File: rtl/slc_queue.sv
module slc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  slc_pkg::push_t  push_i,
  output logic            full_o,
  output slc_pkg::q_out_t pop_o,
  input  logic            pop_ready_i
);
  import slc_pkg::*;

  req_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o      = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign pop_o.valid = (cnt_q != '0);
  assign pop_o.req   = entry_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_o.valid && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.req;
    end
  end

endmodule

// File: rtl/slc_back.sv
module slc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slc_pkg::q_out_t             pop_i,
  output logic                        pop_ready_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [slc_pkg::OUT_W-1:0]   m_axis_tdata,  // [0] hit, [32:1] miss_count, rest 0
  output slc_pkg::bk_stat_t           stat_o
);
  import slc_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CMP  = 1'b1;

  logic              state_q, state_d;
  req_t              req_q;
  logic              valid_q [SETS][WAYS];
  logic [RANK_W-1:0] ranks_q [SETS][WAYS];
  logic [CNT_W-1:0]  miss_q, miss_d;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q;
  logic [CNT_W-1:0]  out_cnt_q;

  logic [TAG_W-1:0]  rd_tag [WAYS];
  logic [WAYS-1:0]   tag_we;
  logic              pop, finish;
  logic              hit, free_found;
  logic [WAY_W-1:0]  hit_way, free_way, lru_way, tgt_way;
  logic [RANK_W-1:0] old_rank;
  logic [RANK_W-1:0] new_ranks [WAYS];

  assign pop_ready_o = (state_q == S_IDLE);
  assign pop         = pop_ready_o && pop_i.valid;
  assign finish      = (state_q == S_CMP) && (!out_valid_q || m_axis_tready);

  // Tag memories, one per way, read on pop, written on a miss at retire
  for (genvar w = 0; w < WAYS; w++) begin : g_way
    assign tag_we[w] = finish && !hit && (tgt_way == WAY_W'(w));
    slc_ram #(
      .WIDTH(TAG_W),
      .DEPTH(SETS)
    ) u_tag_ram (
      .clk_i   (clk_i),
      .we_i    (tag_we[w]),
      .waddr_i (req_q.set_idx),
      .wdata_i (req_q.tag),
      .re_i    (pop),
      .raddr_i (pop_i.req.set_idx),
      .rdata_o (rd_tag[w])
    );
  end

  // Way compare, fill choice and LRU victim
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    lru_way    = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_q[req_q.set_idx][w] && (rd_tag[w] == req_q.tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free_found && !valid_q[req_q.set_idx][w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
      if (ranks_q[req_q.set_idx][w] == RANK_W'(WAYS - 1)) begin
        lru_way = WAY_W'(w);
      end
    end
    if (hit) begin
      tgt_way = hit_way;
    end else if (free_found) begin
      tgt_way = free_way;
    end else begin
      tgt_way = lru_way;
    end
  end

  // Promote target way to most recently used
  always_comb begin
    old_rank = ranks_q[req_q.set_idx][tgt_way];
    for (int w = 0; w < WAYS; w++) begin
      if (tgt_way == WAY_W'(w)) begin
        new_ranks[w] = '0;
      end else if (ranks_q[req_q.set_idx][w] < old_rank) begin
        new_ranks[w] = ranks_q[req_q.set_idx][w] + 1'b1;
      end else begin
        new_ranks[w] = ranks_q[req_q.set_idx][w];
      end
    end
  end

  // Saturating miss count
  assign miss_d = (!hit && (miss_q != '1)) ? miss_q + 1'b1 : miss_q;

  // Sequencer and output slot
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (finish) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      miss_q      <= '0;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          valid_q[s][w] <= 1'b0;
          ranks_q[s][w] <= RANK_W'(w);
        end
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        miss_q                          <= miss_d;
        valid_q[req_q.set_idx][tgt_way] <= 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          ranks_q[req_q.set_idx][w] <= new_ranks[w];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      req_q <= pop_i.req;
    end
    if (finish) begin
      out_hit_q <= hit;
      out_cnt_q <= miss_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_cnt_q, out_hit_q};
  assign stat_o.cmp    = (state_q == S_CMP);
  assign stat_o.done   = finish;

endmodule

// File: rtl/set_assoc_lru_cache_model.sv
// Channel   Dir  Bits  Contents
// s_axis    in   32    byte_address
// m_axis    out  40    [0] hit, [32:1] miss_count, [39:33] zero
//
// Back end: an access occupies it for a tag RAM read, then a compare and LRU/tag
// update; it takes no new access until the last one retires.
// Path from input accept to m_axis_tvalid: queue, tag RAM read, compare, output register.
// Reset empties the queue, clears way valid bits and the miss counter, and sets
// the LRU ranks to way order at once; the tag RAMs are not cleared.
// Stalls: a 2-entry request queue takes input while the back end waits, until it is full;
// the back end holds its compare step while the output register is full and not drained.
module set_assoc_lru_cache_model (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [slc_pkg::ADDR_W-1:0]  s_axis_tdata,   // [31:0] byte_address
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [slc_pkg::OUT_W-1:0]   m_axis_tdata    // [0] hit, [32:1] miss_count
);
  import slc_pkg::*;

  push_t    push;
  q_out_t   q_out;
  logic     q_full;
  logic     pop_ready;
  bk_stat_t bk_stat;

  // Front: accept and split the address
  slc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push)
  );

  // Request queue
  slc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .pop_o       (q_out),
    .pop_ready_i (pop_ready)
  );

  // Back: lookup, replacement and result
  slc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_i         (q_out),
    .pop_ready_o   (pop_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .stat_o        (bk_stat)
  );

`ifndef NO_ASSERTIONS
  // A miss result always carries a nonzero count
  a_miss_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[CNT_W:1] != '0))
    else $error("miss reported with zero miss count");

  // A retiring request shows up on the output next cycle
  a_retire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.done |=> m_axis_tvalid)
    else $error("retired request did not reach output");

  // A waiting request is picked up by an idle back end
  a_pickup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_out.valid && !bk_stat.cmp) |=> bk_stat.cmp)
    else $error("queued request not taken by idle back end");

  // Input backpressure only when requests are pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_out.valid)
    else $error("input stalled with empty queue");
`endif

endmodule
